### hw/rtl/assert_macros.svh
// assertion macros included by the parser core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define FDLP_ASSERT_IMP(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("fdlp assertion failed");

// condition implies consequence in the following cycle
`define FDLP_ASSERT_NXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("fdlp assertion failed");

`endif

### hw/rtl/fdlp_pkg.sv
// types and constants of the fdl telegram parser
`default_nettype none

package fdlp_pkg;

  localparam logic [7:0] DELIM_SC  = 8'hE5;
  localparam logic [7:0] DELIM_SD1 = 8'h10;
  localparam logic [7:0] DELIM_SD2 = 8'h68;
  localparam logic [7:0] DELIM_SD3 = 8'hA2;
  localparam logic [7:0] DELIM_SD4 = 8'hDC;
  localparam logic [7:0] DELIM_ED  = 8'h16;

  localparam logic [7:0] SD3_DATA_LEN = 8'd8;
  localparam logic [7:0] SD2_HDR_LEN  = 8'd3;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  localparam logic [2:0] TYPE_ACK = 3'd0;
  localparam logic [2:0] TYPE_SD1 = 3'd1;
  localparam logic [2:0] TYPE_SD2 = 3'd2;
  localparam logic [2:0] TYPE_SD3 = 3'd3;
  localparam logic [2:0] TYPE_SD4 = 3'd4;

  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_LEN  = 2'd1;
  localparam logic [1:0] CAUSE_FCS  = 2'd2;
  localparam logic [1:0] CAUSE_ED   = 2'd3;

  typedef enum logic [3:0] {
    PH_HUNT,
    PH_LE,
    PH_LER,
    PH_REP,
    PH_DA,
    PH_SA,
    PH_FC,
    PH_DATA,
    PH_FCS,
    PH_ED
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] kind;
    logic [7:0] length;
    logic [7:0] pos;
    logic [7:0] sum;
    logic [7:0] dest;
    logic [7:0] src;
    logic [7:0] func;
  } parse_state_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [2:0] telegram_type;
    logic [7:0] dest_addr;
    logic [7:0] src_addr;
    logic [7:0] func_code;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic [7:0] data_count;
    logic [1:0] reject_cause;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/fdlp_in_if.sv
// input channel carrying received bus words
`default_nettype none

interface fdlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       line_idle;

  modport source (output valid, output rx_byte, output line_idle, input ready);
  modport sink (input valid, input rx_byte, input line_idle, output ready);
endinterface

`default_nettype wire

### hw/rtl/fdlp_out_if.sv
// output channel carrying parser result words
`default_nettype none

interface fdlp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [2:0] telegram_type;
  logic [7:0] dest_addr;
  logic [7:0] src_addr;
  logic [7:0] func_code;
  logic [7:0] data_byte;
  logic [7:0] data_index;
  logic [7:0] data_count;
  logic [1:0] reject_cause;

  modport source (
    output valid, output result_kind, output telegram_type, output dest_addr,
    output src_addr, output func_code, output data_byte, output data_index,
    output data_count, output reject_cause, input ready
  );
  modport sink (
    input valid, input result_kind, input telegram_type, input dest_addr,
    input src_addr, input func_code, input data_byte, input data_index,
    input data_count, input reject_cause, output ready
  );
endinterface

`default_nettype wire

### hw/rtl/fdl_telegram_parser_core.sv
// fdl telegram parser top level: input register, parse step, result register
// Takes one received bus word per cycle, unless a word with a result finds
// the result register still waiting, and reports short acks, tokens, SD1,
// SD2 and SD3 telegrams: one payload word per data byte, then an accept or a
// reject with its cause. A word is registered on entry, parsed against the
// held parser state by the combinational step and its result registered.
// A word that yields no result moves on even while the result register
// waits; line_idle drops a partial telegram.
`default_nettype none

`include "assert_macros.svh"

module fdl_telegram_parser_core
  import fdlp_pkg::*;
#(
  parameter int MAX_DATA = 246
) (
  input  wire         clk,
  input  wire         rst,
  fdlp_in_if.sink     rx,
  fdlp_out_if.source  res
);

  logic         rx_q_valid;
  logic [7:0]   rx_q_byte;
  logic         rx_q_idle;
  parse_state_t state;
  parse_state_t state_next;
  result_t      res_d;
  result_t      res_q;
  logic         has_res;
  logic         res_valid;
  logic         adv;

  fdlp_step #(
    .MAX_DATA (MAX_DATA)
  ) u_step (
    .st        (state),
    .rx_byte   (rx_q_byte),
    .line_idle (rx_q_idle),
    .st_next   (state_next),
    .res       (res_d),
    .has_res   (has_res)
  );

  assign adv      = rx_q_valid && (!res_valid || res.ready || !has_res);
  assign rx.ready = !rx_q_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_q_valid <= 1'b0;
    end else if (rx.ready) begin
      rx_q_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      rx_q_byte <= rx.rx_byte;
      rx_q_idle <= rx.line_idle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_HUNT, default: '0};
    end else if (adv) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (res.ready) begin
        res_valid <= 1'b0;
      end
      if (adv && has_res) begin
        res_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && has_res) begin
      res_q <= res_d;
    end
  end

  assign res.valid         = res_valid;
  assign res.result_kind   = res_q.result_kind;
  assign res.telegram_type = res_q.telegram_type;
  assign res.dest_addr     = res_q.dest_addr;
  assign res.src_addr      = res_q.src_addr;
  assign res.func_code     = res_q.func_code;
  assign res.data_byte     = res_q.data_byte;
  assign res.data_index    = res_q.data_index;
  assign res.data_count    = res_q.data_count;
  assign res.reject_cause  = res_q.reject_cause;

  `FDLP_ASSERT_NXT(a_idle_hunts, adv && rx_q_idle, state.phase == PH_HUNT)
  `FDLP_ASSERT_NXT(a_word_held, rx_q_valid && !adv, rx_q_valid)
  `FDLP_ASSERT_IMP(a_data_len, state.phase == PH_DATA, state.pos < state.length)
  `FDLP_ASSERT_IMP(a_payload_idx, res_valid && res_q.result_kind == KIND_PAYLOAD,
                   res_q.data_index < res_q.data_count)

endmodule

`default_nettype wire

### hw/rtl/fdlp_step.sv
// one-word parse step: next parser state and optional result
`default_nettype none

module fdlp_step
  import fdlp_pkg::*;
#(
  parameter int MAX_DATA = 246
) (
  input  parse_state_t st,
  input  logic [7:0]   rx_byte,
  input  logic         line_idle,
  output parse_state_t st_next,
  output result_t      res,
  output logic         has_res
);

  localparam logic [8:0] LEN_MAX = 9'(MAX_DATA + 3);

  phase_t     phase_next;
  logic       len_bad;
  logic [7:0] pos_inc;

  assign len_bad = (rx_byte != DELIM_SD2) || (st.length != st.pos) ||
                   (st.length < SD2_HDR_LEN) || ({1'b0, st.length} > LEN_MAX);
  assign pos_inc = st.pos + 8'd1;

  always_comb begin
    phase_next = st.phase;
    if (line_idle) begin
      phase_next = PH_HUNT;
    end else begin
      unique case (st.phase)
        PH_HUNT: begin
          if (rx_byte == DELIM_SD2) begin
            phase_next = PH_LE;
          end else if (rx_byte == DELIM_SD1 || rx_byte == DELIM_SD3 ||
                       rx_byte == DELIM_SD4) begin
            phase_next = PH_DA;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_LE:   phase_next = PH_LER;
        PH_LER:  phase_next = PH_REP;
        PH_REP:  phase_next = len_bad ? PH_HUNT : PH_DA;
        PH_DA:   phase_next = PH_SA;
        PH_SA:   phase_next = (st.kind == TYPE_SD4) ? PH_HUNT : PH_FC;
        PH_FC:   phase_next = (st.length != 8'd0) ? PH_DATA : PH_FCS;
        PH_DATA: phase_next = (pos_inc >= st.length) ? PH_FCS : PH_DATA;
        PH_FCS:  phase_next = PH_ED;
        PH_ED:   phase_next = PH_HUNT;
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    logic       start;
    logic [2:0] start_kind;
    logic [7:0] start_len;
    logic [7:0] dbyte;
    logic [7:0] didx;
    logic [1:0] rkind;
    logic [1:0] cause;
    logic       zero_count;

    start      = 1'b0;
    start_kind = TYPE_ACK;
    start_len  = 8'd0;
    dbyte      = 8'd0;
    didx       = 8'd0;
    rkind      = KIND_ACCEPT;
    cause      = CAUSE_NONE;
    zero_count = 1'b0;
    has_res    = 1'b0;
    st_next    = st;

    if (!line_idle) begin
      unique case (st.phase)
        PH_HUNT: begin
          if (rx_byte == DELIM_SC) begin
            start   = 1'b1;
            has_res = 1'b1;
          end else if (rx_byte == DELIM_SD1) begin
            start      = 1'b1;
            start_kind = TYPE_SD1;
          end else if (rx_byte == DELIM_SD2) begin
            start      = 1'b1;
            start_kind = TYPE_SD2;
          end else if (rx_byte == DELIM_SD3) begin
            start      = 1'b1;
            start_kind = TYPE_SD3;
            start_len  = SD3_DATA_LEN;
          end else if (rx_byte == DELIM_SD4) begin
            start      = 1'b1;
            start_kind = TYPE_SD4;
          end
        end
        PH_LE:  st_next.length = rx_byte;
        PH_LER: st_next.pos = rx_byte;
        PH_REP: begin
          if (len_bad) begin
            has_res    = 1'b1;
            rkind      = KIND_REJECT;
            cause      = CAUSE_LEN;
            zero_count = 1'b1;
          end else begin
            st_next.length = st.length - SD2_HDR_LEN;
            st_next.pos    = 8'd0;
          end
        end
        PH_DA: begin
          st_next.dest = rx_byte;
          st_next.sum  = st.sum + rx_byte;
        end
        PH_SA: begin
          st_next.src = rx_byte;
          st_next.sum = st.sum + rx_byte;
          has_res     = (st.kind == TYPE_SD4);
        end
        PH_FC: begin
          st_next.func = rx_byte;
          st_next.sum  = st.sum + rx_byte;
        end
        PH_DATA: begin
          st_next.sum = st.sum + rx_byte;
          st_next.pos = pos_inc;
          has_res     = 1'b1;
          rkind       = KIND_PAYLOAD;
          dbyte       = rx_byte;
          didx        = st.pos;
        end
        PH_FCS: st_next.sum = st.sum ^ rx_byte;
        PH_ED: begin
          has_res = 1'b1;
          if (rx_byte != DELIM_ED) begin
            rkind = KIND_REJECT;
            cause = CAUSE_ED;
          end else if (st.sum != 8'd0) begin
            rkind = KIND_REJECT;
            cause = CAUSE_FCS;
          end
        end
        default: begin
        end
      endcase
    end

    if (start) begin
      st_next.kind   = start_kind;
      st_next.length = start_len;
      st_next.pos    = 8'd0;
      st_next.sum    = 8'd0;
      st_next.dest   = 8'd0;
      st_next.src    = 8'd0;
      st_next.func   = 8'd0;
    end
    st_next.phase = phase_next;

    res.result_kind   = rkind;
    res.telegram_type = st_next.kind;
    res.dest_addr     = st_next.dest;
    res.src_addr      = st_next.src;
    res.func_code     = st_next.func;
    res.data_byte     = dbyte;
    res.data_index    = didx;
    res.data_count    = zero_count ? 8'd0 : st_next.length;
    res.reject_cause  = cause;
  end

endmodule

`default_nettype wire
